// ===== hdl/evb36_pkg.sv =====
`default_nettype none
package evb36_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MID   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // Byte values with a special meaning in the evacuated format.
  localparam logic [7:0] QUOTE_MIN = 8'o360;
  localparam logic [6:0] PAD_CHAR  = 7'o003;
  localparam logic [6:0] CH_BELL   = 7'o007;
  localparam logic [6:0] CH_LF     = 7'o012;
  localparam logic [6:0] CH_CR     = 7'o015;
  localparam logic [6:0] CH_RUB    = 7'o177;

  // Number of bytes that follow a quote byte.
  localparam logic [2:0] QUOTE_BYTES = 3'd4;

  typedef logic [6:0] char_t;
  typedef char_t [3:0] chars_t;

  // One input item as it travels between the stages.
  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_value;
  } item_t;

  // First character that a data byte below the quote range gives.
  function automatic char_t lead_char(input logic [7:0] b);
    char_t c;
    if (b == 8'o012) c = CH_CR;
    else if (b == 8'o015) c = CH_LF;
    else if (b < 8'o200) c = b[6:0];
    else if (b == 8'o356) c = CH_CR;
    else c = CH_RUB;
    return c;
  endfunction

  // Whether a data byte gives a second character.
  function automatic logic has_tail(input logic [7:0] b);
    return (b == 8'o012) || (b == 8'o177) || ((b >= 8'o200) && (b <= 8'o355));
  endfunction

  // Second character of a data byte; only meaningful where has_tail holds.
  function automatic char_t tail_char(input logic [7:0] b);
    char_t c;
    if (b == 8'o012) c = CH_LF;
    else if (b == 8'o177) c = CH_BELL;
    else if (b[6:0] == CH_BELL) c = CH_RUB;
    else if (b[6:0] == CH_LF) c = CH_CR;
    else if (b[6:0] == CH_CR) c = CH_LF;
    else c = b[6:0];
    return c;
  endfunction

  // Five characters packed first to last, low bit zero.
  function automatic logic [35:0] pack_word(input chars_t p, input char_t c);
    return {p[0], p[1], p[2], p[3], c, 1'b0};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/evb36_in_stage.sv =====
`default_nettype none
module evb36_in_stage
  import evb36_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       req_type,
  input  wire logic [7:0] byte_value,
  output logic            item_valid,
  input  wire logic       item_take,
  output item_t           item
);

  // The register takes a new item whenever it is empty or its item moves on.
  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // The payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.req_type   <= req_type;
      item.byte_value <= byte_value;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/evb36_assembler.sv =====
`default_nettype none
module evb36_assembler
  import evb36_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_take,
  input  wire item_t       item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [35:0]      word_value,
  output logic [1:0]       status,
  output logic             last
);

  chars_t      pend;
  chars_t      pend_next;
  logic [2:0]  count;
  logic [2:0]  count_next;
  logic [2:0]  qrem;
  logic [2:0]  qrem_next;
  logic [27:0] accum;
  logic [27:0] accum_next;

  logic        emit;
  logic [35:0] w;
  logic [1:0]  st;
  logic        lst;
  chars_t      padded;
  char_t       c0;
  char_t       c1;
  logic        two;
  logic [7:0]  b;
  logic        slot_free;

  assign b   = item.byte_value;
  assign c0  = lead_char(b);
  assign c1  = tail_char(b);
  assign two = has_tail(b);

  // Partial word filled out with pad characters for the end of the stream.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      padded[k] = (3'(k) < count) ? pend[k] : PAD_CHAR;
    end
  end

  // Next state and result of the item in the input register.
  always_comb begin
    pend_next  = pend;
    count_next = count;
    qrem_next  = qrem;
    accum_next = accum;
    emit       = 1'b0;
    w          = '0;
    st         = ST_OK;
    lst        = 1'b0;
    if (item.req_type) begin
      // End of stream always leaves the state clear.
      count_next = '0;
      qrem_next  = '0;
      accum_next = '0;
      if (qrem != 3'd0) begin
        emit = 1'b1;
        st   = ST_TRUNC;
        lst  = 1'b1;
      end else if (count != 3'd0) begin
        emit = 1'b1;
        lst  = 1'b1;
        w    = pack_word(padded, PAD_CHAR);
      end
    end else if (qrem != 3'd0) begin
      // Bytes of a quoted word are plain data.
      if (qrem == 3'd1) begin
        emit       = 1'b1;
        w          = {accum, b};
        qrem_next  = '0;
        accum_next = '0;
      end else begin
        accum_next = {accum[19:0], b};
        qrem_next  = qrem - 3'd1;
      end
    end else if (b >= QUOTE_MIN) begin
      if (count != 3'd0) begin
        // A quote in the middle of a word drops the partial word.
        emit       = 1'b1;
        st         = ST_MID;
        count_next = '0;
      end else begin
        accum_next = {24'd0, b[3:0]};
        qrem_next  = QUOTE_BYTES;
      end
    end else if (count == 3'd4) begin
      // The first character completes the word; a second one starts the next.
      emit = 1'b1;
      w    = pack_word(pend, c0);
      if (two) begin
        pend_next[0] = c1;
        count_next   = 3'd1;
      end else begin
        count_next   = 3'd0;
      end
    end else if (count == 3'd3 && two) begin
      // The second character completes the word.
      emit         = 1'b1;
      pend_next[3] = c0;
      w            = pack_word(pend_next, c1);
      count_next   = 3'd0;
    end else begin
      pend_next[count[1:0]] = c0;
      if (two) begin
        pend_next[count[1:0] + 2'd1] = c1;
        count_next = count + 3'd2;
      end else begin
        count_next = count + 3'd1;
      end
    end
  end

  // An item moves on unless its result would overwrite one still waiting.
  assign slot_free = !out_valid || out_ready;
  assign item_take = item_valid && (!emit || slot_free);

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      qrem  <= '0;
    end else if (item_take) begin
      count <= count_next;
      qrem  <= qrem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      pend  <= pend_next;
      accum <= accum_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      word_value <= w;
      status     <= st;
      last       <= lst;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/evacuated_byte_to_36bit_word_decoder.sv =====
// An accepted item is held in the input register; its result is then loaded into the result register.
// Throughput: one item per cycle while the input does not stall, set by the single pass
// from the input register through the character tables to the result register.
// Input stalls only while a result waits and the held item has a result of its own.
// Reset (rst, synchronous) empties both registers and clears the partial word.
`default_nettype none
module evacuated_byte_to_36bit_word_decoder
  import evb36_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  byte_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [35:0]      word_value,
  output logic [1:0]       status,
  output logic             last
);

  logic  item_valid;
  logic  item_take;
  item_t item;

  // Input register.
  evb36_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .byte_value (byte_value),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  // Character mapping, word packing and result register.
  evb36_assembler u_asm (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_value (word_value),
    .status     (status),
    .last       (last)
  );

endmodule
`default_nettype wire

// ===== sim/evacuated_byte_to_36bit_word_decoder_test.sv =====
`default_nettype none
module evacuated_byte_to_36bit_word_decoder_test;
  import evb36_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 1100;
  localparam int CALM_FROM   = 950;

  // One decoded result as the block gives it.
  typedef struct packed {
    logic [35:0] w;
    logic [1:0]  st;
    logic        lst;
  } word_res_t;

  // One row of the directed stimulus; typed rows carry their result.
  typedef struct packed {
    logic      rq;
    logic [7:0] b;
    logic      typed;
    word_res_t want;
  } plan_row_t;

  localparam plan_row_t PLAN [23] = '{
    '{1'b1, 8'o000, 1'b0, '0},
    '{1'b0, 8'o377, 1'b0, '0},
    '{1'b0, 8'hFF,  1'b0, '0},
    '{1'b0, 8'hFF,  1'b0, '0},
    '{1'b0, 8'hFF,  1'b0, '0},
    '{1'b0, 8'hFF,  1'b1, '{36'hF_FFFF_FFFF, ST_OK, 1'b0}},
    '{1'b0, 8'o000, 1'b0, '0},
    '{1'b0, 8'o012, 1'b0, '0},
    '{1'b0, 8'o176, 1'b0, '0},
    '{1'b0, 8'o207, 1'b0, '0},
    '{1'b0, 8'o212, 1'b0, '0},
    '{1'b0, 8'o215, 1'b0, '0},
    '{1'b0, 8'o015, 1'b0, '0},
    '{1'b0, 8'o356, 1'b0, '0},
    '{1'b0, 8'o357, 1'b0, '0},
    '{1'b0, 8'o177, 1'b0, '0},
    '{1'b0, 8'o355, 1'b0, '0},
    '{1'b0, 8'o360, 1'b1, '{36'd0, ST_MID, 1'b0}},
    '{1'b0, 8'o000, 1'b0, '0},
    '{1'b1, 8'hA5,  1'b0, '0},
    '{1'b0, 8'o360, 1'b0, '0},
    '{1'b0, 8'h12,  1'b0, '0},
    '{1'b1, 8'h00,  1'b1, '{36'd0, ST_TRUNC, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [7:0]  byte_value = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [35:0] word_value;
  logic [1:0]  status;
  logic        last;

  // Decoder state as predicted from the accepted items.
  char_t       chars_held [4];
  logic [2:0]  held_count;
  logic [2:0]  quote_left;
  logic [27:0] quote_bits;

  word_res_t   words_due [$];
  int          errors = 0;
  int          cycles = 0;
  int          sent = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;

  evacuated_byte_to_36bit_word_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .byte_value (byte_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_value (word_value),
    .status     (status),
    .last       (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clears the partial word and any quoted word in progress.
  task automatic clear_state();
    for (int k = 0; k < 4; k++) chars_held[k] = '0;
    held_count = '0;
    quote_left = '0;
    quote_bits = '0;
  endtask

  // First character of a byte below the quote range.
  function automatic char_t first_char(input logic [7:0] b);
    char_t c;
    case (b)
      8'o012: c = CH_CR;
      8'o015: c = CH_LF;
      8'o356: c = CH_CR;
      default: c = b[7] ? CH_RUB : b[6:0];
    endcase
    return c;
  endfunction

  // Second character, where the byte gives one.
  task automatic second_char(input logic [7:0] b, output bit more, output char_t c);
    more = 1'b1;
    c = '0;
    if (b == 8'o012) begin
      c = CH_LF;
    end else if (b == 8'o177) begin
      c = CH_BELL;
    end else if (b >= 8'o200 && b <= 8'o355) begin
      case (b[6:0])
        CH_BELL: c = CH_RUB;
        CH_LF:   c = CH_CR;
        CH_CR:   c = CH_LF;
        default: c = b[6:0];
      endcase
    end else begin
      more = 1'b0;
    end
  endtask

  // Adds one character; the fifth completes a word and empties the store.
  task automatic take_char(input char_t c, inout bit got, inout logic [35:0] w);
    if (held_count == 3'd4) begin
      w = {chars_held[0], chars_held[1], chars_held[2], chars_held[3], c, 1'b0};
      for (int k = 0; k < 4; k++) chars_held[k] = '0;
      held_count = '0;
      got = 1'b1;
    end else begin
      chars_held[held_count[1:0]] = c;
      held_count = held_count + 3'd1;
    end
  endtask

  // Works out the result, if any, that one accepted item causes.
  task automatic decode_item(input logic rq, input logic [7:0] b,
                             output bit got, output word_res_t r);
    char_t       c;
    bit          more;
    logic [35:0] w;
    got = 1'b0;
    r = '0;
    w = '0;
    if (rq) begin
      if (quote_left != 0) begin
        got = 1'b1;
        r.st = ST_TRUNC;
        r.lst = 1'b1;
      end else if (held_count != 0) begin
        while (!got) take_char(PAD_CHAR, got, w);
        r.w = w;
        r.lst = 1'b1;
      end
      clear_state();
    end else if (quote_left != 0) begin
      if (quote_left == 3'd1) begin
        got = 1'b1;
        r.w = {quote_bits, b};
        clear_state();
      end else begin
        quote_bits = {quote_bits[19:0], b};
        quote_left = quote_left - 3'd1;
      end
    end else if (b >= QUOTE_MIN) begin
      if (held_count != 0) begin
        got = 1'b1;
        r.st = ST_MID;
        clear_state();
      end else begin
        quote_bits = {24'd0, b[3:0]};
        quote_left = QUOTE_BYTES;
      end
    end else begin
      take_char(first_char(b), got, w);
      second_char(b, more, c);
      if (more) take_char(c, got, w);
      r.w = w;
    end
  endtask

  // Offers one item, waits for it to be taken and records what it should cause.
  task automatic send_item(input logic rq, input logic [7:0] b,
                           input logic typed, input word_res_t want);
    bit        got;
    word_res_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = rq;
    byte_value = b;
    do @(posedge clk); while (!in_ready);
    decode_item(rq, b, got, r);
    if (typed) words_due.push_back(want);
    else if (got) words_due.push_back(r);
    sent++;
    @(negedge clk);
  endtask

  // The receiver stalls in short bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Each result taken is compared with the oldest expected one.
  always @(posedge clk) begin : check_results
    word_res_t due;
    if (!rst && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        $display("%0t: result with none expected: word %h status %0d last %0b",
                 $time, word_value, status, last);
        errors++;
      end else begin
        due = words_due.pop_front();
        if (word_value !== due.w) begin
          $display("%0t: word_value expected %h, got %h", $time, due.w, word_value);
          errors++;
        end
        if (status !== due.st) begin
          $display("%0t: status expected %0d, got %0d", $time, due.st, status);
          errors++;
        end
        if (last !== due.lst) begin
          $display("%0t: last expected %0b, got %0b", $time, due.lst, last);
          errors++;
        end
      end
    end
  end

  // A run that stops making progress ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : run
    int pick;
    clear_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items: table extremes, quoted words and each error case.
    foreach (PLAN[i]) send_item(PLAN[i].rq, PLAN[i].b, PLAN[i].typed, PLAN[i].want);

    // Random items, mostly well-formed runs of characters and quoted words.
    while (sent < ITEM_TARGET) begin
      if (sent >= CALM_FROM) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(1, 12))
          send_item(1'b0, 8'($urandom_range(0, 8'o357)), 1'b0, '0);
      end else if (pick < 78) begin
        if (held_count != 0 && $urandom_range(0, 1) == 1)
          send_item(1'b1, 8'($urandom), 1'b0, '0);
        send_item(1'b0, 8'($urandom_range(8'o360, 8'o377)), 1'b0, '0);
        repeat (4) send_item(1'b0, 8'($urandom), 1'b0, '0);
      end else if (pick < 88) begin
        send_item(1'b1, 8'($urandom), 1'b0, '0);
      end else if (pick < 94) begin
        send_item(1'b0, 8'($urandom_range(8'o360, 8'o377)), 1'b0, '0);
        repeat ($urandom_range(0, 3)) send_item(1'b0, 8'($urandom), 1'b0, '0);
        send_item(1'b1, 8'($urandom), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 6)) send_item(1'b0, 8'($urandom), 1'b0, '0);
      end
    end
    in_valid = 1'b0;
    idle_on = 1'b0;

    // Drain the outstanding results, then allow for the pipeline depth.
    while (words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/evb36_pkg.sv
hdl/evb36_in_stage.sv
hdl/evb36_assembler.sv
hdl/evacuated_byte_to_36bit_word_decoder.sv
sim/evacuated_byte_to_36bit_word_decoder_test.sv
